/* design/ovle_pkg.sv */
// Shared types and constants for the ordered value list engine.
package ovle_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CountOutW = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_e;

  typedef struct packed {
    op_e                       op;
    logic signed [ValueW-1:0]  key;
    logic signed [ValueW-1:0]  new_value;
  } req_t;

  typedef struct packed {
    logic                  found;
    status_e               status;
    logic [CountOutW-1:0]  entry_count;
  } rsp_t;

  // Control that the sequencer broadcasts to every cell of the row.
  typedef struct packed {
    logic                 capture;
    logic                 apply;
    logic                 full;
    op_e                  op;
    logic [ValueW-1:0]    key;
    logic [ValueW-1:0]    new_value;
  } cmd_t;

endpackage

/* design/ovle_cell.sv */
// One list position: holds a single entry and its match flag for the current transaction.
module ovle_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ovle_pkg::cmd_t               cmd_i,
  input  logic                         valid_i,
  input  logic                         tail_i,
  input  logic [ovle_pkg::ValueW-1:0]  next_entry_i,
  input  logic                         before_i,
  output logic                         before_o,
  output logic [ovle_pkg::ValueW-1:0]  entry_o
);

  logic [ovle_pkg::ValueW-1:0] entry_q, entry_d;
  logic                        match_q, match_d;
  logic                        found;

  // An earlier match anywhere in the row reaches this cell through before_i.
  assign before_o = before_i | match_q;
  assign found    = before_o;
  assign entry_o  = entry_q;

  always_comb begin
    match_d = match_q;
    entry_d = entry_q;
    if (cmd_i.capture) begin
      match_d = valid_i && (entry_q == cmd_i.key);
    end
    if (cmd_i.apply) begin
      unique case (cmd_i.op)
        ovle_pkg::OP_APPEND: begin
          if (tail_i && !cmd_i.full) begin
            entry_d = cmd_i.key;
          end
        end
        ovle_pkg::OP_DELETE: begin
          // Every position from the first match onwards takes its right neighbour.
          if (found) begin
            entry_d = next_entry_i;
          end
        end
        ovle_pkg::OP_UPDATE: begin
          if (match_q && !before_i) begin
            entry_d = cmd_i.new_value;
          end
        end
        ovle_pkg::OP_SEARCH: begin
          entry_d = entry_q;
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* design/ordered_value_list_engine_core.sv */
// Top level of the ordered value list engine: sequencer, entry count and the row of cells.
//
// The engine keeps up to CAPACITY signed 32-bit values in order of arrival and serves one
// transaction at a time: append at the tail, delete the oldest entry equal to the key, search
// for the key, or replace the oldest entry equal to the key with new_value. A transaction is
// taken at a rising edge where start_i is high and busy_o is low. In the cycle of acceptance
// each cell compares its entry with the key, and in the following cycle the row of cells
// resolves the oldest match through a neighbour-to-neighbour chain and applies the change. The
// result appears on result_o in the cycle after that, marked by done_o for exactly one cycle,
// and result_o holds it until the next result; busy_o is already low then, so a new transaction
// can be started in the same cycle as the previous result is shown, but not while busy_o is
// high. The receiver cannot stall results, and none are held back. A full list drops an append
// and reports it in the status; entry_count carries the low five bits of the count held after
// the transaction.
module ordered_value_list_engine_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ovle_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            done_o,
  output ovle_pkg::rsp_t  result_o
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  ovle_pkg::state_e state_q, state_d;
  ovle_pkg::req_t   req_q;
  logic [CountW-1:0] count_q, count_d;
  logic             done_q;
  ovle_pkg::rsp_t   rsp_q, rsp_d;
  logic             accept;
  logic             full;
  logic             found;
  ovle_pkg::cmd_t   cmd;

  logic [ovle_pkg::ValueW-1:0] entry [CAPACITY];
  logic [CAPACITY:0]           match_chain;
  logic [CountW+ovle_pkg::CountOutW-1:0] count_ext;

  assign busy_o = (state_q == ovle_pkg::S_APPLY);
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CountW'(CAPACITY));

  // The compare runs on the incoming key; the update runs on the registered transaction.
  always_comb begin
    cmd.capture   = accept;
    cmd.apply     = busy_o;
    cmd.full      = full;
    cmd.op        = req_q.op;
    cmd.key       = busy_o ? req_q.key : req_i.key;
    cmd.new_value = req_q.new_value;
  end

  // The row of cells; the match chain enters at the oldest position.
  assign match_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ovle_pkg::ValueW-1:0] next_entry;

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    ovle_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .valid_i      (CountW'(i) < count_q),
      .tail_i       (CountW'(i) == count_q),
      .next_entry_i (next_entry),
      .before_i     (match_chain[i]),
      .before_o     (match_chain[i+1]),
      .entry_o      (entry[i])
    );
  end

  assign found = match_chain[CAPACITY];

  // Sequencer, count update and result formation.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rsp_d   = rsp_q;
    unique case (state_q)
      ovle_pkg::S_IDLE: begin
        if (accept) begin
          state_d = ovle_pkg::S_APPLY;
        end
      end
      ovle_pkg::S_APPLY: begin
        state_d      = ovle_pkg::S_IDLE;
        rsp_d.found  = 1'b0;
        rsp_d.status = ovle_pkg::STS_DONE;
        if (req_q.op == ovle_pkg::OP_APPEND) begin
          if (full) begin
            rsp_d.status = ovle_pkg::STS_FULL;
          end else begin
            count_d = count_q + CountW'(1);
          end
        end else if (found) begin
          rsp_d.found = 1'b1;
          if (req_q.op == ovle_pkg::OP_DELETE) begin
            count_d = count_q - CountW'(1);
          end
        end else begin
          rsp_d.status = ovle_pkg::STS_NOT_FOUND;
        end
        rsp_d.entry_count = count_ext[ovle_pkg::CountOutW-1:0];
      end
      default: begin
        state_d = ovle_pkg::S_IDLE;
      end
    endcase
  end

  assign count_ext = {{ovle_pkg::CountOutW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ovle_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == ovle_pkg::S_APPLY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;

  // The count never leaves the range of the list.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Every update cycle is followed by exactly one result.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o)
    else $error("update cycle without result");

  // A result is only shown after an update cycle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a transaction");

  // A dropped append leaves the list full.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ovle_pkg::STS_FULL) |-> full)
    else $error("append dropped while list not full");

  // A match always reports completion.
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |-> result_o.status == ovle_pkg::STS_DONE)
    else $error("match reported with error status");

endmodule
